>>> rtl/rn48_pkg.sv
package rn48_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W      = 8;
  localparam int KEY_SPACE  = 256;
  localparam int MAP_W      = 6;
  localparam int CMD_W      = 2;
  localparam int REF_W      = 32;
  localparam int STAT_W     = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_BITS   = 41;
  localparam int OUT_TDATA_W = 48;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF       = 48;
  localparam int HANDLE_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_FIND,
    S_SHIFT,
    S_OUT
  } state_t;

  // Key map port request: one read and one write per cycle
  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic             wr_en;
    logic [KEY_W-1:0] wr_key;
    logic [MAP_W-1:0] wr_slot;
  } map_req_t;

  // Slot store port request; indexes are cut to the store depth downstream
  typedef struct packed {
    logic             rd_en;
    logic [MAP_W-1:0] rd_idx;
    logic             wr_en;
    logic [MAP_W-1:0] wr_idx;
  } slot_req_t;

endpackage

>>> rtl/rn48_key_map.sv
module rn48_key_map
  import rn48_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  map_req_t         req,
  output logic [MAP_W-1:0] rd_slot
);

  logic [MAP_W-1:0]     map_mem [KEY_SPACE];
  logic [KEY_SPACE-1:0] vld_r;
  logic [MAP_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_mem[req.wr_key] <= req.wr_slot;
    end
    if (req.rd_en) begin
      rd_data_r <= map_mem[req.rd_key];
    end
  end

  // Per-entry valid bits: an entry never written reads as unmapped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_key] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_key];
      end
    end
  end

  assign rd_slot = rd_vld_r ? rd_data_r : '0;

endmodule

>>> rtl/rn48_slot_store.sv
module rn48_slot_store
  import rn48_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                         clk,
  input  slot_req_t                    req,
  input  logic [KEY_W+HANDLE_BITS-1:0] wr_data,
  output logic [KEY_W+HANDLE_BITS-1:0] rd_data
);

  localparam int SLOT_AW = $clog2(SLOTS);

  // Each entry holds {key, handle}; the key lets a shift renumber the map
  logic [KEY_W+HANDLE_BITS-1:0] slot_mem [SLOTS];
  logic [KEY_W+HANDLE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_idx[SLOT_AW-1:0]] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= slot_mem[req.rd_idx[SLOT_AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/rn48_ctrl.sv
module rn48_ctrl
  import rn48_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transaction
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [CMD_W-1:0]             in_cmd,
  input  logic [KEY_W-1:0]             in_key,
  input  logic [REF_W-1:0]             in_ref,
  // result transaction
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic                         out_found,
  output logic [REF_W-1:0]             out_child,
  output logic [STAT_W-1:0]            out_status,
  output logic [MAP_W-1:0]             out_occ,
  // memories
  output map_req_t                     map_req,
  input  logic [MAP_W-1:0]             map_rd_slot,
  output slot_req_t                    slot_req,
  output logic [KEY_W+HANDLE_BITS-1:0] slot_wr_data,
  input  logic [KEY_W+HANDLE_BITS-1:0] slot_rd_data
);

  localparam int KEEP_BITS = (HANDLE_BITS < REF_W) ? HANDLE_BITS : REF_W;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [MAP_W-1:0]       count_r, count_nxt;
  logic [MAP_W-1:0]       idx_r, idx_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [REF_W-1:0]       res_child_r, res_child_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [REF_W-1:0]       out_child_r, out_child_nxt;
  logic [STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [MAP_W-1:0]       out_occ_r, out_occ_nxt;

  logic                   hit;
  logic [MAP_W-1:0]       idx_inc;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [REF_W-1:0]       rd_child;

  // Keep the low handle bits of the incoming reference, and back
  always_comb begin
    in_handle = '0;
    rd_child  = '0;
    for (int b = 0; b < KEEP_BITS; b++) begin
      in_handle[b] = in_ref[b];
      rd_child[b]  = slot_rd_data[b];
    end
  end

  assign hit     = (map_rd_slot != '0) && (map_rd_slot <= count_r);
  assign idx_inc = idx_r + MAP_W'(1);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    idx_r        <= idx_nxt;
    res_found_r  <= res_found_nxt;
    res_child_r  <= res_child_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_child_r  <= out_child_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Sequencer: look up the map, then touch the slot store
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_found_nxt  = res_found_r;
    res_child_nxt  = res_child_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_child_nxt  = out_child_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    in_tready      = 1'b0;
    map_req        = '0;
    slot_req       = '0;
    slot_wr_data   = {key_r, handle_r};

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt        = cmd_t'(in_cmd);
          key_nxt        = in_key;
          handle_nxt     = in_handle;
          map_req.rd_en  = 1'b1;
          map_req.rd_key = in_key;
          state_nxt      = S_MAP;
        end
      end

      S_MAP: begin
        res_found_nxt  = hit;
        res_child_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_OUT;
        unique case (cmd_r)
          CMD_FIND: begin
            if (hit) begin
              slot_req.rd_en  = 1'b1;
              slot_req.rd_idx = map_rd_slot - MAP_W'(1);
              state_nxt       = S_FIND;
            end else begin
              res_status_nxt = ST_ABSENT;
            end
          end
          CMD_ADD: begin
            if (hit) begin
              // update the existing slot in place
              slot_req.wr_en  = 1'b1;
              slot_req.wr_idx = map_rd_slot - MAP_W'(1);
            end else if (count_r < MAP_W'(SLOTS)) begin
              // append in the next free slot
              slot_req.wr_en  = 1'b1;
              slot_req.wr_idx = count_r;
              map_req.wr_en   = 1'b1;
              map_req.wr_key  = key_r;
              map_req.wr_slot = count_r + MAP_W'(1);
              count_nxt       = count_r + MAP_W'(1);
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
          CMD_REMOVE: begin
            if (hit) begin
              map_req.wr_en   = 1'b1;
              map_req.wr_key  = key_r;
              map_req.wr_slot = '0;
              if (map_rd_slot < count_r) begin
                // start compaction with the slot after the removed one
                slot_req.rd_en  = 1'b1;
                slot_req.rd_idx = map_rd_slot;
                idx_nxt         = map_rd_slot;
                state_nxt       = S_SHIFT;
              end else begin
                count_nxt = count_r - MAP_W'(1);
              end
            end else begin
              res_status_nxt = ST_ABSENT;
            end
          end
          CMD_NOP: begin
            res_status_nxt = ST_OK;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
      end

      S_FIND: begin
        res_child_nxt = rd_child;
        state_nxt     = S_OUT;
      end

      S_SHIFT: begin
        // move slot idx down by one and renumber its key
        slot_req.wr_en  = 1'b1;
        slot_req.wr_idx = idx_r - MAP_W'(1);
        slot_wr_data    = slot_rd_data;
        map_req.wr_en   = 1'b1;
        map_req.wr_key  = slot_rd_data[KEY_W+HANDLE_BITS-1:HANDLE_BITS];
        map_req.wr_slot = idx_r;
        if (idx_inc < count_r) begin
          slot_req.rd_en  = 1'b1;
          slot_req.rd_idx = idx_inc;
          idx_nxt         = idx_inc;
        end else begin
          count_nxt = count_r - MAP_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_child_nxt  = res_child_r;
          out_status_nxt = res_status_r;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_found  = out_found_r;
  assign out_child  = out_child_r;
  assign out_status = out_status_r;
  assign out_occ    = out_occ_r;

`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAP_W'(SLOTS))
    else $error("child count exceeds slot capacity");

  a_shift_idx : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> (idx_r != '0) && (idx_r < count_r))
    else $error("compaction index outside occupied slots");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + MAP_W'(1))
          || (count_r == $past(count_r) - MAP_W'(1)))
    else $error("child count moved by more than one");

  a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && (res_status_r == ST_FULL) |-> count_r == MAP_W'(SLOTS))
    else $error("full reported with free slots");
`endif

endmodule

>>> rtl/radix_node48_child_table.sv
// Channel  Direction  tdata (low bit up)                      tuser
// in_      slave      key[7:0], child_ref[39:8]               cmd[1:0]
// out_     master     found[0], child_out[32:1], status[34:33],  -
//                     occupancy[40:35], zero pad[47:41]
//
// One item at a time. Find passes through S_MAP, S_FIND and S_OUT; add and
// absent keys skip S_FIND; each then loads the output register. Remove adds
// one S_SHIFT step per entry above the removed slot, occupancy counted before
// the remove: the slot store shifts one entry per cycle through its single
// read and write port while the moved key is renumbered in the key map.
// Reset clears the key map valid bits and the child count at once; no sweep.
// A result waiting on out_tready holds the next item in its last state only.
module radix_node48_child_table
  import rn48_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key, child_ref
  input  logic [CMD_W-1:0]       in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // found, child_out, status, occupancy
);

  map_req_t                     map_req;
  logic [MAP_W-1:0]             map_rd_slot;
  slot_req_t                    slot_req;
  logic [KEY_W+HANDLE_BITS-1:0] slot_wr_data;
  logic [KEY_W+HANDLE_BITS-1:0] slot_rd_data;
  logic                         out_found;
  logic [REF_W-1:0]             out_child;
  logic [STAT_W-1:0]            out_status;
  logic [MAP_W-1:0]             out_occ;

  rn48_ctrl #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (in_tuser),
    .in_key       (in_tdata[KEY_W-1:0]),
    .in_ref       (in_tdata[KEY_W+REF_W-1:KEY_W]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_found    (out_found),
    .out_child    (out_child),
    .out_status   (out_status),
    .out_occ      (out_occ),
    .map_req      (map_req),
    .map_rd_slot  (map_rd_slot),
    .slot_req     (slot_req),
    .slot_wr_data (slot_wr_data),
    .slot_rd_data (slot_rd_data)
  );

  rn48_key_map u_key_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_slot (map_rd_slot)
  );

  rn48_slot_store #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_slot_store (
    .clk     (clk),
    .req     (slot_req),
    .wr_data (slot_wr_data),
    .rd_data (slot_rd_data)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), out_occ, out_status, out_child, out_found};

endmodule

>>> tb/radix_node48_child_table_tb.sv
module radix_node48_child_table_tb;
  import rn48_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 64;

  typedef struct {
    logic             found;
    logic [REF_W-1:0] child;
    status_t          status;
    logic [MAP_W-1:0] occupancy;
  } node_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // key, child_ref
  logic [CMD_W-1:0]       in_tuser = CMD_NOP;   // cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // found, child_out, status, occupancy

  // Shadow copy of the node's child table
  logic [MAP_W-1:0] key_slot [KEY_SPACE];
  logic [REF_W-1:0] child_handles [SLOTS];
  int               child_total;

  node_result_t pending_results [$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_req_cnt = 0;
  int           hold_ack_cnt = 0;
  int           hold_left = 0;
  int           stall_cycles = 0;

  radix_node48_child_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow table and return the result it yields
  function automatic node_result_t apply_child_op(cmd_t op, logic [KEY_W-1:0] key,
                                                  logic [REF_W-1:0] handle);
    node_result_t res;
    int           slot;
    slot = key_slot[key];
    if (slot > child_total) slot = 0;
    res.found     = (slot != 0);
    res.child     = '0;
    res.status    = ST_OK;
    case (op)
      CMD_FIND: begin
        if (slot != 0) res.child = child_handles[slot-1];
        else res.status = ST_ABSENT;
      end
      CMD_ADD: begin
        if (slot != 0) begin
          child_handles[slot-1] = handle;
        end else if (child_total < SLOTS) begin
          child_handles[child_total] = handle;
          child_total++;
          key_slot[key] = MAP_W'(child_total);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (slot != 0) begin
          key_slot[key] = '0;
          // compact the slots above the hole and renumber their keys
          for (int i = slot - 1; i + 1 < child_total; i++)
            child_handles[i] = child_handles[i+1];
          child_total--;
          child_handles[child_total] = '0;
          for (int j = 0; j < KEY_SPACE; j++)
            if (key_slot[j] > slot) key_slot[j]--;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    res.occupancy = MAP_W'(child_total);
    return res;
  endfunction

  // Offer one transaction, wait for the handshake, record what it should yield
  task automatic send_op(cmd_t op, logic [KEY_W-1:0] key, logic [REF_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {handle, key};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(apply_child_op(op, key, handle));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_req_cnt != hold_ack_cnt && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_ack_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    node_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[0] !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, out_tdata[0]);
          mismatch_count++;
        end
        if (out_tdata[32:1] !== exp_res.child) begin
          $error("child_out: expected %h, got %h", exp_res.child, out_tdata[32:1]);
          mismatch_count++;
        end
        if (out_tdata[34:33] !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_tdata[34:33]);
          mismatch_count++;
        end
        if (out_tdata[40:35] !== exp_res.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_res.occupancy, out_tdata[40:35]);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else if (rst_n) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Edges of the fields and the hit, miss, update and shift cases
  task automatic test_directed();
    send_op(CMD_FIND,   8'd0,   32'h1234_5678);
    send_op(CMD_REMOVE, 8'd0,   32'h0);
    send_op(CMD_NOP,    8'd0,   32'hFFFF_FFFF);
    send_op(CMD_ADD,    8'd0,   32'h0000_0000);
    send_op(CMD_ADD,    8'd255, 32'hFFFF_FFFF);
    send_op(CMD_NOP,    8'd255, 32'h0);
    send_op(CMD_FIND,   8'd255, 32'h0);
    send_op(CMD_FIND,   8'd0,   32'hFFFF_FFFF);
    send_op(CMD_ADD,    8'd255, 32'h5A5A_5A5A);
    send_op(CMD_FIND,   8'd255, 32'h0);
    send_op(CMD_ADD,    8'd128, 32'hA5A5_A5A5);
    send_op(CMD_REMOVE, 8'd0,   32'h0);
    send_op(CMD_FIND,   8'd255, 32'h0);
    send_op(CMD_FIND,   8'd128, 32'h0);
    send_op(CMD_FIND,   8'd0,   32'h0);
    send_op(CMD_REMOVE, 8'd0,   32'h0);
    send_op(CMD_REMOVE, 8'd128, 32'h0);
    send_op(CMD_REMOVE, 8'd255, 32'h0);
    send_op(CMD_FIND,   8'd255, 32'h0);
  endtask

  // Fill all slots, hit the full limit, update in place while full, then punch holes
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++)
      send_op(CMD_ADD, KEY_W'(i * 5 + 3), $urandom);
    send_op(CMD_ADD,    8'd200, $urandom);
    send_op(CMD_ADD,    8'd3,   32'hDEAD_BEEF);
    send_op(CMD_FIND,   8'd3,   32'h0);
    send_op(CMD_REMOVE, 8'd103, 32'h0);
    send_op(CMD_FIND,   8'd238, 32'h0);
    send_op(CMD_REMOVE, 8'd3,   32'h0);
    send_op(CMD_REMOVE, 8'd238, 32'h0);
    send_op(CMD_ADD,    8'd200, $urandom);
    send_op(CMD_FIND,   8'd200, 32'h0);
    send_op(CMD_FIND,   8'd108, 32'h0);
  endtask

  // Random traffic over a sliding key window; the mix steers the fill level
  task automatic test_random_mix(int count, int add_pct, int rem_pct, int key_span);
    int unsigned base;
    int unsigned roll;
    cmd_t        op;
    base = $urandom_range(255);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 63) base = $urandom_range(255);
      roll = $urandom_range(99);
      if (roll < add_pct) op = CMD_ADD;
      else if (roll < add_pct + rem_pct) op = CMD_REMOVE;
      else if (roll < 95) op = CMD_FIND;
      else op = CMD_NOP;
      send_op(op, KEY_W'(base + $urandom_range(key_span - 1)), $urandom);
    end
  endtask

  // Keep offering while the receiver holds off, so the input stalls
  task automatic test_backpressure();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_req_cnt++;
    test_random_mix(16, 50, 20, 64);
    send_idle_pct = saved_idle;
  endtask

  task automatic run_random_phase();
    test_random_mix(140, 60, 25, 64);
    test_random_mix(120, 25, 60, 56);
    test_random_mix(180, 40, 40, 256);
  endtask

  initial begin
    for (int i = 0; i < KEY_SPACE; i++) key_slot[i] = '0;
    for (int i = 0; i < SLOTS; i++) child_handles[i] = '0;
    child_total = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 65;
    test_directed();
    test_full_table();
    run_random_phase();
    test_backpressure();

    send_idle_pct = 65;
    recv_idle_pct = 27;
    run_random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase();
    in_tvalid <= 1'b0;

    // drain outstanding results, then allow for a trailing remove
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rn48_pkg.sv
rtl/rn48_key_map.sv
rtl/rn48_slot_store.sv
rtl/rn48_ctrl.sv
rtl/radix_node48_child_table.sv
tb/radix_node48_child_table_tb.sv
